// ===== design/ps2dec_pkg.sv =====
package ps2dec_pkg;

  localparam int unsigned CodeW   = 7;
  localparam int unsigned CharW   = 7;
  localparam int unsigned RomAddrW = 6;
  localparam int unsigned TableLen = 59;

  localparam logic [CodeW-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CodeW-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [CodeW-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [CodeW-1:0] KEY_ALT    = 7'h38;
  localparam logic [CodeW-1:0] KEY_CAPS   = 7'h3A;

  localparam logic [CharW-1:0] CHAR_LOW_A = 7'h61;
  localparam logic [CharW-1:0] CHAR_LOW_Z = 7'h7A;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } flags_t;

  typedef struct packed {
    logic [CharW-1:0] upper;
    logic [CharW-1:0] lower;
  } rom_entry_t;

  // US set-1 map, {shifted, unshifted}; unused slots read as zero
  function automatic rom_entry_t char_rom(input logic [RomAddrW-1:0] idx);
    rom_entry_t e;
    unique case (idx)
      6'd1:  e = {7'h1B, 7'h1B};
      6'd2:  e = {7'h21, 7'h31};
      6'd3:  e = {7'h40, 7'h32};
      6'd4:  e = {7'h23, 7'h33};
      6'd5:  e = {7'h24, 7'h34};
      6'd6:  e = {7'h25, 7'h35};
      6'd7:  e = {7'h5E, 7'h36};
      6'd8:  e = {7'h26, 7'h37};
      6'd9:  e = {7'h2A, 7'h38};
      6'd10: e = {7'h28, 7'h39};
      6'd11: e = {7'h29, 7'h30};
      6'd12: e = {7'h5F, 7'h2D};
      6'd13: e = {7'h2B, 7'h3D};
      6'd14: e = {7'h08, 7'h08};
      6'd15: e = {7'h09, 7'h09};
      6'd16: e = {7'h51, 7'h71};
      6'd17: e = {7'h57, 7'h77};
      6'd18: e = {7'h45, 7'h65};
      6'd19: e = {7'h52, 7'h72};
      6'd20: e = {7'h54, 7'h74};
      6'd21: e = {7'h59, 7'h79};
      6'd22: e = {7'h55, 7'h75};
      6'd23: e = {7'h49, 7'h69};
      6'd24: e = {7'h4F, 7'h6F};
      6'd25: e = {7'h50, 7'h70};
      6'd26: e = {7'h7B, 7'h5B};
      6'd27: e = {7'h7D, 7'h5D};
      6'd28: e = {7'h0A, 7'h0A};
      6'd30: e = {7'h41, 7'h61};
      6'd31: e = {7'h53, 7'h73};
      6'd32: e = {7'h44, 7'h64};
      6'd33: e = {7'h46, 7'h66};
      6'd34: e = {7'h47, 7'h67};
      6'd35: e = {7'h48, 7'h68};
      6'd36: e = {7'h4A, 7'h6A};
      6'd37: e = {7'h4B, 7'h6B};
      6'd38: e = {7'h4C, 7'h6C};
      6'd39: e = {7'h3A, 7'h3B};
      6'd40: e = {7'h22, 7'h27};
      6'd41: e = {7'h7E, 7'h60};
      6'd43: e = {7'h7C, 7'h5C};
      6'd44: e = {7'h5A, 7'h7A};
      6'd45: e = {7'h58, 7'h78};
      6'd46: e = {7'h43, 7'h63};
      6'd47: e = {7'h56, 7'h76};
      6'd48: e = {7'h42, 7'h62};
      6'd49: e = {7'h4E, 7'h6E};
      6'd50: e = {7'h4D, 7'h6D};
      6'd51: e = {7'h3C, 7'h2C};
      6'd52: e = {7'h3E, 7'h2E};
      6'd53: e = {7'h3F, 7'h2F};
      6'd55: e = {7'h2A, 7'h2A};
      6'd57: e = {7'h20, 7'h20};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== design/ps2dec_rom.sv =====
module ps2dec_rom (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [ps2dec_pkg::RomAddrW-1:0]    rd_addr,
  output ps2dec_pkg::rom_entry_t             rd_data
);

  ps2dec_pkg::rom_entry_t rd_data_r;

  // synchronous read, data held while stage 1 stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ps2dec_pkg::char_rom(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ps2dec_flags.sv =====
module ps2dec_flags (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd_en,
  input  logic [7:0]                       scan_byte,
  input  ps2dec_pkg::rom_entry_t           rom_data,
  output ps2dec_pkg::flags_t               flags_nxt,
  output logic [ps2dec_pkg::CharW-1:0]     char_nxt,
  output ps2dec_pkg::flags_t               flags_cur
);

  ps2dec_pkg::flags_t flags_r;
  ps2dec_pkg::flags_t flags_upd;
  logic                            released;
  logic [ps2dec_pkg::CodeW-1:0]    code;
  logic                            is_letter;
  logic                            shifted_sel;
  logic                            is_mod;

  assign released = scan_byte[7];
  assign code     = scan_byte[6:0];

  always_comb begin
    flags_upd = flags_r;
    is_mod    = 1'b1;
    unique case (code)
      ps2dec_pkg::KEY_LSHIFT,
      ps2dec_pkg::KEY_RSHIFT: flags_upd.shift = !released;
      ps2dec_pkg::KEY_CTRL:   flags_upd.ctrl  = !released;
      ps2dec_pkg::KEY_ALT:    flags_upd.alt   = !released;
      ps2dec_pkg::KEY_CAPS:   flags_upd.caps  = flags_r.caps ^ !released;
      default:                is_mod          = 1'b0;
    endcase
  end

  // caps lock flips the shift choice for letter keys only
  assign is_letter = (rom_data.lower >= ps2dec_pkg::CHAR_LOW_A) &&
                     (rom_data.lower <= ps2dec_pkg::CHAR_LOW_Z);
  assign shifted_sel = flags_r.shift ^ (flags_r.caps && is_letter);

  always_comb begin
    if (released || is_mod ||
        (code >= ps2dec_pkg::CodeW'(ps2dec_pkg::TableLen))) begin
      char_nxt = '0;
    end else begin
      char_nxt = shifted_sel ? rom_data.upper : rom_data.lower;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (upd_en) begin
      flags_r <= flags_upd;
    end
  end

  assign flags_nxt = flags_upd;
  assign flags_cur = flags_r;

endmodule

// ===== design/ps2_scancode_to_ascii_decoder.sv =====
// Pipeline: an input transfer starts the ROM read and loads stage 1; the flag
//   update and character select then load the output register.
// Throughput: one scancode per cycle while the output is not stalled; the
//   synchronous character ROM read and the in-order flag update in stage 1 set the pace.
// Reset: synchronous, active low; clears shift/ctrl/alt/caps flags and all
//   stage valids. Payload registers are not reset.
module ps2_scancode_to_ascii_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_scan_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_key_event,
  output logic [ps2dec_pkg::CharW-1:0] out_char_code,
  output logic [ps2dec_pkg::CodeW-1:0] out_key_code,
  output logic                         out_shift_held,
  output logic                         out_ctrl_held,
  output logic                         out_alt_held,
  output logic                         out_caps_on
);

  logic                         in_xfer;
  logic                         out_load;
  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [7:0]                   s1_byte_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [ps2dec_pkg::CharW-1:0] out_char_r;
  logic [ps2dec_pkg::CodeW-1:0] out_code_r;
  ps2dec_pkg::flags_t           out_flags_r;
  ps2dec_pkg::rom_entry_t       rom_data;
  ps2dec_pkg::flags_t           flags_nxt;
  ps2dec_pkg::flags_t           flags_cur;
  logic [ps2dec_pkg::CharW-1:0] char_nxt;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign in_xfer  = in_valid && in_ready;

  ps2dec_rom u_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (in_scan_byte[ps2dec_pkg::RomAddrW-1:0]),
    .rd_data (rom_data)
  );

  ps2dec_flags u_flags (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (out_load),
    .scan_byte (s1_byte_r),
    .rom_data  (rom_data),
    .flags_nxt (flags_nxt),
    .char_nxt  (char_nxt),
    .flags_cur (flags_cur)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_scan_byte;
    end
    if (out_load) begin
      out_char_r  <= char_nxt;
      out_code_r  <= s1_byte_r[6:0];
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_event  = (out_char_r != '0);
  assign out_char_code  = out_char_r;
  assign out_key_code   = out_code_r;
  assign out_shift_held = out_flags_r.shift;
  assign out_ctrl_held  = out_flags_r.ctrl;
  assign out_alt_held   = out_flags_r.alt;
  assign out_caps_on    = out_flags_r.caps;

  // caps press moving out of stage 1 toggles the stored caps flag
  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (s1_byte_r == {1'b0, ps2dec_pkg::KEY_CAPS}))
    |=> (flags_cur.caps != $past(flags_cur.caps)))
    else $error("caps flag did not toggle on caps press");

  // modifier keys never produce a character
  a_mod_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_key_code == ps2dec_pkg::KEY_LSHIFT) ||
                   (out_key_code == ps2dec_pkg::KEY_RSHIFT) ||
                   (out_key_code == ps2dec_pkg::KEY_CTRL) ||
                   (out_key_code == ps2dec_pkg::KEY_ALT) ||
                   (out_key_code == ps2dec_pkg::KEY_CAPS)))
    |-> !out_key_event)
    else $error("modifier key produced a key event");

  // reported flags match the stored flags once the result is registered
  a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_flags_r == flags_cur))
    else $error("result flags differ from stored flags");

  // stage 1 always drains into a free output slot
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |-> in_ready)
    else $error("input stalled with free output slot");

endmodule
